>>> hw/rtl/wbmp_stream_decoder_assert.svh
// Assertion macros for the WBMP stream decoder.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef WBMP_STREAM_DECODER_ASSERT_SVH
`define WBMP_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WBMP_ASSERT_SAME(label, clock, reset, cond, expect_now) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expect_now)) \
    else $error("wbmp decoder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WBMP_ASSERT_NEXT(label, clock, reset, cond, expect_next) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expect_next)) \
    else $error("wbmp decoder: next-cycle check failed");

`endif

>>> hw/rtl/wbmp_pkg.sv
// Shared types and constants of the WBMP stream decoder.
// Used by the channel interfaces and the decoder; depends on nothing.
package wbmp_pkg;

  localparam int unsigned MAX_DIM_DEFAULT = 4096;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DIM_O_W  = 13;
  localparam int unsigned ROW_O_W  = 12;
  localparam int unsigned COL_O_W  = 9;

  // Continuation integers carry seven payload bits per byte; bit 7 means more follow.
  localparam int unsigned        DIGIT_W      = 7;
  localparam int unsigned        CONT_BIT     = 7;
  localparam logic [BYTE_W-1:0]  PAYLOAD_MASK = 8'h7F;

  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_FIXHDR = 3'd2,
    PH_WIDTH  = 3'd3,
    PH_HEIGHT = 3'd4,
    PH_PIXELS = 3'd5
  } phase_t;

endpackage

>>> hw/rtl/wbmp_byte_if.sv
// Input channel of the WBMP stream decoder: one file byte per request.
// Depends on wbmp_pkg.
interface wbmp_byte_if;
  import wbmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              image_start;

  modport source(output valid, in_byte, image_start, input ready);
  modport sink(input valid, in_byte, image_start, output ready);
endinterface

>>> hw/rtl/wbmp_result_if.sv
// Result channel of the WBMP stream decoder: header, pixel byte or error.
// Depends on wbmp_pkg.
interface wbmp_result_if;
  import wbmp_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [DIM_O_W-1:0] image_width;
  logic [DIM_O_W-1:0] image_height;
  logic [BYTE_W-1:0]  pixel_byte;
  logic [ROW_O_W-1:0] row_index;
  logic [COL_O_W-1:0] byte_column;
  logic               last_in_row;
  logic               last_in_image;

  modport source(output valid, result_kind, image_width, image_height, pixel_byte,
                 row_index, byte_column, last_in_row, last_in_image, input ready);
  modport sink(input valid, result_kind, image_width, image_height, pixel_byte,
               row_index, byte_column, last_in_row, last_in_image, output ready);
endinterface

>>> hw/rtl/wbmp_stream_decoder.sv
// WBMP type 0 stream decoder: header parse, dimension check and pixel byte tagging.
// Depends on wbmp_pkg, wbmp_byte_if, wbmp_result_if and wbmp_stream_decoder_assert.svh.
//
//   channel   dir   payload                                      requests
//   stream    in    in_byte, image_start                         one per file byte
//   result    out   kind, width, height, pixel, row, col, marks  zero or one per byte
//
// Each byte is decoded in the cycle it is accepted; its result is written to the output
// register at the end of that cycle; a new byte can be accepted every cycle the output is free.
// The byte path is one pass of phase logic plus the 7-bit shift and MAX_DIM compare.
// Reset (rst, synchronous) returns the parser to idle and empties the output register.
// A stalled result blocks input only while it is not being taken in the same cycle.
module wbmp_stream_decoder #(
  parameter int unsigned MAX_DIM = wbmp_pkg::MAX_DIM_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  wbmp_byte_if.sink    stream,
  wbmp_result_if.source result
);
  import wbmp_pkg::*;

  `include "wbmp_stream_decoder_assert.svh"

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned ACC_W = DIM_W + DIGIT_W;
  localparam logic [ACC_W-1:0] MAX_ACC = ACC_W'(MAX_DIM);

  // Parser state.
  phase_t           phase, phase_next;
  logic [DIM_W-1:0] acc, acc_next;
  logic             ovf, ovf_next;
  logic [DIM_W-1:0] width_reg, width_reg_next;
  logic [DIM_W-1:0] height_reg, height_reg_next;
  logic [DIM_W-1:0] row_cnt, row_cnt_next;
  logic [DIM_W-1:0] col_cnt, col_cnt_next;

  // Output register.
  logic               res_valid;
  logic [KIND_W-1:0]  res_kind, res_kind_next;
  logic [DIM_O_W-1:0] res_width, res_width_next;
  logic [DIM_O_W-1:0] res_height, res_height_next;
  logic [BYTE_W-1:0]  res_pixel, res_pixel_next;
  logic [ROW_O_W-1:0] res_row, res_row_next;
  logic [COL_O_W-1:0] res_col, res_col_next;
  logic               res_lr, res_lr_next;
  logic               res_li, res_li_next;
  logic               emit;

  logic             fire;
  logic             out_free;
  logic [BYTE_W-1:0] b;
  phase_t           ph_eff;
  logic [DIM_W-1:0] acc_eff, row_eff, col_eff;
  logic             ovf_eff;
  logic [ACC_W-1:0] dim_next;
  logic             dim_over, dim_end;
  logic [DIM_W-1:0] acc_take;
  logic             ovf_take;
  logic [DIM_W:0]   bpr, col_inc, row_inc;
  logic             lr, li;

  assign out_free     = !res_valid || result.ready;
  assign stream.ready = out_free;
  assign fire         = stream.valid && out_free;
  assign b            = stream.in_byte;

  // A start mark restarts parsing with the current byte.
  assign ph_eff  = stream.image_start ? PH_TYPE : phase;
  assign acc_eff = stream.image_start ? '0 : acc;
  assign ovf_eff = stream.image_start ? 1'b0 : ovf;
  assign row_eff = stream.image_start ? '0 : row_cnt;
  assign col_eff = stream.image_start ? '0 : col_cnt;

  // A digit that would push the value past MAX_DIM is dropped and flagged.
  assign dim_next = {acc_eff, {DIGIT_W{1'b0}}} | ACC_W'(b & PAYLOAD_MASK);
  assign dim_over = dim_next > MAX_ACC;
  assign acc_take = dim_over ? acc_eff : dim_next[DIM_W-1:0];
  assign ovf_take = ovf_eff | dim_over;
  assign dim_end  = !b[CONT_BIT];

  assign bpr     = ({1'b0, width_reg} + (DIM_W+1)'(7)) >> 3;
  assign col_inc = {1'b0, col_eff} + (DIM_W+1)'(1);
  assign row_inc = {1'b0, row_eff} + (DIM_W+1)'(1);
  assign lr      = col_inc >= bpr;
  assign li      = lr && (row_inc >= {1'b0, height_reg});

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    ovf_next        = ovf;
    width_reg_next  = width_reg;
    height_reg_next = height_reg;
    row_cnt_next    = row_cnt;
    col_cnt_next    = col_cnt;
    emit            = 1'b0;
    res_kind_next   = KIND_HEADER;
    res_width_next  = '0;
    res_height_next = '0;
    res_pixel_next  = '0;
    res_row_next    = '0;
    res_col_next    = '0;
    res_lr_next     = 1'b0;
    res_li_next     = 1'b0;
    if (fire) begin
      phase_next   = ph_eff;
      acc_next     = acc_eff;
      ovf_next     = ovf_eff;
      row_cnt_next = row_eff;
      col_cnt_next = col_eff;
      unique case (ph_eff)
        PH_IDLE: begin
        end
        PH_TYPE: begin
          ovf_next = ovf_eff | ((b & PAYLOAD_MASK) != '0);
          if (dim_end) begin
            if (ovf_next) begin
              emit          = 1'b1;
              res_kind_next = KIND_ERROR;
              phase_next    = PH_IDLE;
            end else begin
              phase_next = PH_FIXHDR;
            end
          end
        end
        PH_FIXHDR: begin
          if (b != '0) begin
            emit          = 1'b1;
            res_kind_next = KIND_ERROR;
            phase_next    = PH_IDLE;
          end else begin
            acc_next   = '0;
            ovf_next   = 1'b0;
            phase_next = PH_WIDTH;
          end
        end
        PH_WIDTH: begin
          acc_next = acc_take;
          ovf_next = ovf_take;
          if (dim_end) begin
            if (ovf_take || acc_take == '0) begin
              emit          = 1'b1;
              res_kind_next = KIND_ERROR;
              phase_next    = PH_IDLE;
            end else begin
              width_reg_next = acc_take;
              acc_next       = '0;
              ovf_next       = 1'b0;
              phase_next     = PH_HEIGHT;
            end
          end
        end
        PH_HEIGHT: begin
          acc_next = acc_take;
          ovf_next = ovf_take;
          if (dim_end) begin
            emit = 1'b1;
            if (ovf_take || acc_take == '0) begin
              res_kind_next = KIND_ERROR;
              phase_next    = PH_IDLE;
            end else begin
              height_reg_next = acc_take;
              acc_next        = '0;
              row_cnt_next    = '0;
              col_cnt_next    = '0;
              phase_next      = PH_PIXELS;
              res_kind_next   = KIND_HEADER;
              res_width_next  = DIM_O_W'(width_reg);
              res_height_next = DIM_O_W'(acc_take);
            end
          end
        end
        PH_PIXELS: begin
          emit           = 1'b1;
          res_kind_next  = KIND_PIXEL;
          res_pixel_next = ~b;
          res_row_next   = ROW_O_W'(row_eff);
          res_col_next   = COL_O_W'(col_eff);
          res_lr_next    = lr;
          res_li_next    = li;
          if (li) begin
            phase_next   = PH_IDLE;
            row_cnt_next = '0;
            col_cnt_next = '0;
          end else if (lr) begin
            row_cnt_next = row_inc[DIM_W-1:0];
            col_cnt_next = '0;
          end else begin
            col_cnt_next = col_inc[DIM_W-1:0];
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      acc        <= '0;
      ovf        <= 1'b0;
      width_reg  <= '0;
      height_reg <= '0;
      row_cnt    <= '0;
      col_cnt    <= '0;
      res_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      acc        <= acc_next;
      ovf        <= ovf_next;
      width_reg  <= width_reg_next;
      height_reg <= height_reg_next;
      row_cnt    <= row_cnt_next;
      col_cnt    <= col_cnt_next;
      if (out_free) begin
        res_valid <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res_kind   <= res_kind_next;
      res_width  <= res_width_next;
      res_height <= res_height_next;
      res_pixel  <= res_pixel_next;
      res_row    <= res_row_next;
      res_col    <= res_col_next;
      res_lr     <= res_lr_next;
      res_li     <= res_li_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.result_kind   = res_kind;
  assign result.image_width   = res_width;
  assign result.image_height  = res_height;
  assign result.pixel_byte    = res_pixel;
  assign result.row_index     = res_row;
  assign result.byte_column   = res_col;
  assign result.last_in_row   = res_lr;
  assign result.last_in_image = res_li;

  // The column counter never runs past the bytes of one row.
  `WBMP_ASSERT_SAME(a_col_in_row, clk, rst, phase == PH_PIXELS, {1'b0, col_cnt} < bpr)
  // A header result is only given once both dimensions are stored and nonzero.
  `WBMP_ASSERT_SAME(a_hdr_dims, clk, rst, res_valid && res_kind == KIND_HEADER,
                    width_reg != '0 && height_reg != '0)
  // A fresh start with a zero type byte moves straight to the fixed header byte.
  `WBMP_ASSERT_NEXT(a_start_type0, clk, rst,
                    fire && stream.image_start && b == '0, phase == PH_FIXHDR)
  // The last byte of an image ends the pixel phase.
  `WBMP_ASSERT_NEXT(a_last_to_idle, clk, rst,
                    fire && ph_eff == PH_PIXELS && li, phase == PH_IDLE && row_cnt == '0)

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the WBMP stream decoder: directed header and pixel cases,
// then random files, broken headers and noise, checked against an in-bench decoder model.
// Depends on wbmp_pkg, wbmp_byte_if, wbmp_result_if and wbmp_stream_decoder.
module testbench;
  import wbmp_pkg::*;

  localparam int unsigned    MAX_DIM       = MAX_DIM_DEFAULT;
  localparam int unsigned    RANDOM_ITEMS  = 750;
  localparam int unsigned    DRAIN_LIMIT   = 2000;
  localparam logic [BYTE_W-1:0] ZERO_DIGIT_MORE = 8'h80;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DIM_O_W-1:0] width;
    logic [DIM_O_W-1:0] height;
    logic [BYTE_W-1:0]  pixel;
    logic [ROW_O_W-1:0] row;
    logic [COL_O_W-1:0] col;
    logic               lr;
    logic               li;
  } dec_result_t;

  // How a directed row is checked: by the decoder model, as no result, or as typed.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RESULT} row_mode_t;

  typedef enum int unsigned {
    FLAW_TYPE, FLAW_FIXHDR, FLAW_ZERO_W, FLAW_ZERO_H, FLAW_BIG_W, FLAW_BIG_H
  } hdr_flaw_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
    row_mode_t         mode;
    dec_result_t       want;
  } stim_row_t;

  localparam dec_result_t NO_RES = '0;
  localparam int N_DIR = 27;

  stim_row_t dir_rows [0:N_DIR-1] = '{
    '{8'hAB, 1'b0, CHK_NONE,   NO_RES},
    '{8'h00, 1'b1, CHK_MODEL,  NO_RES},
    '{8'h00, 1'b0, CHK_MODEL,  NO_RES},
    '{8'h01, 1'b0, CHK_MODEL,  NO_RES},
    '{8'h01, 1'b0, CHK_RESULT, '{KIND_HEADER, 13'd1, 13'd1, 8'h00, 12'd0, 9'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, CHK_RESULT, '{KIND_PIXEL, 13'd0, 13'd0, 8'hFF, 12'd0, 9'd0, 1'b1, 1'b1}},
    '{8'h81, 1'b1, CHK_NONE,   NO_RES},
    '{8'h00, 1'b0, CHK_RESULT, '{KIND_ERROR, 13'd0, 13'd0, 8'h00, 12'd0, 9'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b1, CHK_MODEL,  NO_RES},
    '{8'h55, 1'b0, CHK_RESULT, '{KIND_ERROR, 13'd0, 13'd0, 8'h00, 12'd0, 9'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b1, CHK_MODEL,  NO_RES},
    '{8'h00, 1'b0, CHK_MODEL,  NO_RES},
    '{8'h00, 1'b0, CHK_RESULT, '{KIND_ERROR, 13'd0, 13'd0, 8'h00, 12'd0, 9'd0, 1'b0, 1'b0}},
    '{8'h80, 1'b1, CHK_MODEL,  NO_RES},
    '{8'h00, 1'b0, CHK_MODEL,  NO_RES},
    '{8'h00, 1'b0, CHK_MODEL,  NO_RES},
    '{8'hA0, 1'b0, CHK_MODEL,  NO_RES},
    '{8'h00, 1'b0, CHK_MODEL,  NO_RES},
    '{8'h80, 1'b0, CHK_MODEL,  NO_RES},
    '{8'h01, 1'b0, CHK_RESULT, '{KIND_HEADER, 13'd4096, 13'd1, 8'h00, 12'd0, 9'd0, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, CHK_RESULT, '{KIND_PIXEL, 13'd0, 13'd0, 8'h00, 12'd0, 9'd0, 1'b0, 1'b0}},
    '{8'h7F, 1'b0, CHK_MODEL,  NO_RES},
    '{8'h00, 1'b1, CHK_MODEL,  NO_RES},
    '{8'h00, 1'b0, CHK_MODEL,  NO_RES},
    '{8'hA0, 1'b0, CHK_MODEL,  NO_RES},
    '{8'h01, 1'b0, CHK_RESULT, '{KIND_ERROR, 13'd0, 13'd0, 8'h00, 12'd0, 9'd0, 1'b0, 1'b0}},
    '{8'h3C, 1'b0, CHK_NONE,   NO_RES}
  };

  logic clk = 1'b0;
  logic rst;

  wbmp_byte_if   stream_ch();
  wbmp_result_if result_ch();

  wbmp_stream_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decoder model state.
  phase_t             ph      = PH_IDLE;
  int unsigned        dim_acc = 0;
  bit                 dim_ovf = 1'b0;
  logic [DIM_O_W-1:0] img_w   = '0;
  logic [DIM_O_W-1:0] img_h   = '0;
  logic [ROW_O_W-1:0] cur_row = '0;
  logic [COL_O_W-1:0] cur_col = '0;

  dec_result_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned busy_items = 0;
  bit          no_idle    = 1'b0;
  int unsigned rx_hold    = 0;

  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic start,
                                      output bit got, output dec_result_t r);
    int unsigned nxt;
    int unsigned bpr;
    bit          lr;
    bit          li;
    bit          bad;
    got = 1'b0;
    bad = 1'b0;
    r   = '0;
    if (start) begin
      ph      = PH_TYPE;
      dim_acc = 0;
      dim_ovf = 1'b0;
      cur_row = '0;
      cur_col = '0;
    end
    case (ph)
      PH_TYPE: begin
        if ((b & PAYLOAD_MASK) != 0) dim_ovf = 1'b1;
        if (!b[CONT_BIT]) begin
          if (dim_ovf) bad = 1'b1;
          else ph = PH_FIXHDR;
        end
      end
      PH_FIXHDR: begin
        if (b != 0) begin
          bad = 1'b1;
        end else begin
          dim_acc = 0;
          dim_ovf = 1'b0;
          ph      = PH_WIDTH;
        end
      end
      PH_WIDTH, PH_HEIGHT: begin
        nxt = (dim_acc << DIGIT_W) | (b & PAYLOAD_MASK);
        if (nxt > MAX_DIM) dim_ovf = 1'b1;
        else dim_acc = nxt;
        if (!b[CONT_BIT]) begin
          if (dim_ovf || dim_acc == 0) begin
            bad = 1'b1;
          end else if (ph == PH_WIDTH) begin
            img_w   = dim_acc[DIM_O_W-1:0];
            dim_acc = 0;
            dim_ovf = 1'b0;
            ph      = PH_HEIGHT;
          end else begin
            img_h    = dim_acc[DIM_O_W-1:0];
            dim_acc  = 0;
            cur_row  = '0;
            cur_col  = '0;
            ph       = PH_PIXELS;
            got      = 1'b1;
            r.kind   = KIND_HEADER;
            r.width  = img_w;
            r.height = img_h;
          end
        end
      end
      PH_PIXELS: begin
        bpr     = (img_w + 7) / 8;
        lr      = (cur_col + 1 >= bpr);
        li      = lr && (cur_row + 1 >= img_h);
        got     = 1'b1;
        r.kind  = KIND_PIXEL;
        r.pixel = ~b;
        r.row   = cur_row;
        r.col   = cur_col;
        r.lr    = lr;
        r.li    = li;
        if (li) begin
          ph      = PH_IDLE;
          cur_row = '0;
          cur_col = '0;
        end else if (lr) begin
          cur_row = cur_row + 1'b1;
          cur_col = '0;
        end else begin
          cur_col = cur_col + 1'b1;
        end
      end
      default: ph = PH_IDLE;
    endcase
    if (bad) begin
      got    = 1'b1;
      r      = '0;
      r.kind = KIND_ERROR;
      ph     = PH_IDLE;
    end
  endfunction

  task automatic report(input string what, input longint got_v, input longint want_v);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got_v, want_v);
    mismatches++;
  endtask

  task automatic compare_result(input dec_result_t got_r);
    dec_result_t want;
    if (pending_results.size() == 0) begin
      report("result with nothing expected, kind", got_r.kind, 0);
    end else begin
      want = pending_results.pop_front();
      if (got_r.kind   !== want.kind)   report("result_kind",   got_r.kind,   want.kind);
      if (got_r.width  !== want.width)  report("image_width",   got_r.width,  want.width);
      if (got_r.height !== want.height) report("image_height",  got_r.height, want.height);
      if (got_r.pixel  !== want.pixel)  report("pixel_byte",    got_r.pixel,  want.pixel);
      if (got_r.row    !== want.row)    report("row_index",     got_r.row,    want.row);
      if (got_r.col    !== want.col)    report("byte_column",   got_r.col,    want.col);
      if (got_r.lr     !== want.lr)     report("last_in_row",   got_r.lr,     want.lr);
      if (got_r.li     !== want.li)     report("last_in_image", got_r.li,     want.li);
    end
  endtask

  // Result side: take a request, then may hold ready low for a random while, unless no_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_hold = 0;
    end else if (result_ch.valid && result_ch.ready) begin
      compare_result('{result_ch.result_kind, result_ch.image_width, result_ch.image_height,
                       result_ch.pixel_byte, result_ch.row_index, result_ch.byte_column,
                       result_ch.last_in_row, result_ch.last_in_image});
      rx_hold = no_idle ? 0 : $urandom_range(0, 14);
      result_ch.ready <= (rx_hold == 0);
    end else if (!result_ch.ready) begin
      if (rx_hold > 0) rx_hold--;
      result_ch.ready <= (rx_hold == 0);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic start,
                           input row_mode_t mode = CHK_MODEL, input dec_result_t want = '0);
    int unsigned gap;
    bit          got;
    dec_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      stream_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_ch.valid       <= 1'b1;
    stream_ch.in_byte     <= data;
    stream_ch.image_start <= start;
    do @(posedge clk); while (!stream_ch.ready);
    if (start || ph != PH_IDLE) busy_items++;
    decode_byte(data, start, got, r);
    if (mode == CHK_RESULT) pending_results.push_back(want);
    else if (mode == CHK_MODEL && got) pending_results.push_back(r);
  endtask

  // Sends a big-endian continuation integer, optionally with leading zero digits.
  task automatic send_dim(input int unsigned value, input int unsigned lead, input logic start);
    int          n;
    int          i;
    logic [BYTE_W-1:0] b;
    logic        st;
    st = start;
    repeat (lead) begin
      send_byte(ZERO_DIGIT_MORE, st);
      st = 1'b0;
    end
    n = 1;
    while ((value >> (DIGIT_W * n)) != 0) n++;
    for (i = n - 1; i >= 0; i--) begin
      b = BYTE_W'((value >> (DIGIT_W * i)) & PAYLOAD_MASK);
      b[CONT_BIT] = (i != 0);
      send_byte(b, st);
      st = 1'b0;
    end
  endtask

  function automatic int unsigned pick_lead();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  task automatic send_image();
    int unsigned sel;
    int unsigned w;
    int unsigned h;
    int unsigned npix;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      w = $urandom_range(2000, MAX_DIM);
      h = 1;
    end else if (sel < 7) begin
      w = $urandom_range(1, 16);
      h = $urandom_range(3000, MAX_DIM);
    end else begin
      w = $urandom_range(1, 40);
      h = $urandom_range(1, 5);
    end
    send_dim(0, pick_lead(), 1'b1);
    send_byte(8'h00, 1'b0);
    send_dim(w, pick_lead(), 1'b0);
    send_dim(h, pick_lead(), 1'b0);
    npix = ((w + 7) / 8) * h;
    // Some files are cut short; the next file start abandons them.
    if (npix > 600 || $urandom_range(0, 9) == 0)
      npix = $urandom_range(0, (npix > 60) ? 60 : npix);
    repeat (npix) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_bad_header();
    hdr_flaw_t flaw;
    flaw = hdr_flaw_t'($urandom_range(FLAW_TYPE, FLAW_BIG_H));
    if (flaw == FLAW_TYPE) begin
      send_dim($urandom_range(1, 20000), pick_lead(), 1'b1);
    end else begin
      send_dim(0, pick_lead(), 1'b1);
      if (flaw == FLAW_FIXHDR) begin
        send_byte(BYTE_W'($urandom_range(1, 255)), 1'b0);
      end else begin
        send_byte(8'h00, 1'b0);
        case (flaw)
          FLAW_ZERO_W: send_dim(0, pick_lead(), 1'b0);
          FLAW_BIG_W:  send_dim($urandom_range(MAX_DIM + 1, 65535), pick_lead(), 1'b0);
          default: begin
            send_dim($urandom_range(1, 64), pick_lead(), 1'b0);
            if (flaw == FLAW_ZERO_H) send_dim(0, pick_lead(), 1'b0);
            else send_dim($urandom_range(MAX_DIM + 1, 65535), pick_lead(), 1'b0);
          end
        endcase
      end
    end
    // Bytes after an error are ignored until the next file start.
    repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic drain();
    stream_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned pick;
    int unsigned i;
    rst                   <= 1'b1;
    stream_ch.valid       <= 1'b0;
    stream_ch.in_byte     <= '0;
    stream_ch.image_start <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++)
      send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].mode, dir_rows[i].want);
    drain();

    busy_items = 0;
    while (busy_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_image();
      end else if (pick < 85) begin
        send_bad_header();
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 8))
          send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        no_idle = !no_idle;
        drain();
      end
    end

    stream_ch.valid <= 1'b0;
    for (i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report("results never produced, count", pending_results.size(), 0);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
